### rtl/hgl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hgl_pkg;

  // Default coordinate width, two's complement
  localparam int COORD_WIDTH_DEF = 6;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FLAG,
    ST_RUN
  } state_t;

  // Control from the sequencer to each coordinate lane
  typedef struct packed {
    logic load;   // take start value and step, clear remainder
    logic adv;    // move on to the next hex
  } lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/hgl_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one beat per line to draw
interface hgl_in_if import hgl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_q;
  logic signed [COORD_WIDTH-1:0] start_r;
  logic signed [COORD_WIDTH-1:0] end_q;
  logic signed [COORD_WIDTH-1:0] end_r;

  modport source (output valid, start_q, start_r, end_q, end_r, input ready);
  modport sink   (input valid, start_q, start_r, end_q, end_r, output ready);
endinterface

// Result channel: one beat per hex on the line, or one flag beat for an out-of-range request
interface hgl_out_if import hgl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] hex_q;
  logic signed [COORD_WIDTH-1:0] hex_r;
  logic signed [COORD_WIDTH-1:0] hex_s;
  logic        [COORD_WIDTH-1:0] step_index;
  logic        [COORD_WIDTH-1:0] path_length;
  logic                          last;
  logic                          out_of_range;

  modport source (output valid, hex_q, hex_r, hex_s, step_index, path_length, last,
                  out_of_range, input ready);
  modport sink   (input valid, hex_q, hex_r, hex_s, step_index, path_length, last,
                  out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/hex_grid_line_draw_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Hex line drawing in cube coordinates, exact arithmetic over denominator N.
// The first hex is registered in the run state, after the range check state.
// A request with distance N gives N+1 hexes at one per cycle while the result
// channel is not stalled, the three coordinate lanes advancing one hex per cycle.
// The request channel is busy until the last hex or the out-of-range beat is loaded.
// Reset (synchronous, active high) returns the sequencer to idle and drops valid.
module hex_grid_line_draw_top import hgl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hgl_in_if.sink    req,
  hgl_out_if.source hex
);

  localparam int W  = COORD_WIDTH;
  localparam int XW = COORD_WIDTH + 2;
  localparam logic signed [XW-1:0] BOUND = XW'((1 << (W - 1)) - 1);

  state_t state;
  state_t state_next;

  // Captured request
  logic signed [W-1:0] sq;
  logic signed [W-1:0] sr;
  logic signed [W-1:0] eq;
  logic signed [W-1:0] er;

  logic [W-1:0] n_len;
  logic [W-1:0] den;
  logic [W-1:0] idx;

  // Output register
  logic                o_valid;
  logic signed [W-1:0] o_q;
  logic signed [W-1:0] o_r;
  logic signed [W-1:0] o_s;
  logic        [W-1:0] o_idx;
  logic        [W-1:0] o_len;
  logic                o_last;
  logic                o_oor;

  logic signed [XW-1:0] xsq, xsr, xss, xeq, xer, xes;
  logic signed [XW-1:0] xdq, xdr, xds;
  logic signed [XW-1:0] adq, adr, ads, span;
  logic                 oor;

  lane_ctrl_t           lctl;
  logic                 out_free;
  logic                 load_run;
  logic                 load_flag;

  logic signed [XW-1:0] rq, rr, rs;
  logic        [W-1:0]  erq, err_r, ers;
  logic signed [XW-1:0] fq, fr, fs;

  assign out_free = !o_valid || hex.ready;

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      sq <= req.start_q;
      sr <= req.start_r;
      eq <= req.end_q;
      er <= req.end_r;
    end
  end

  // Range check, deltas and distance
  always_comb begin
    xsq = XW'(sq);
    xsr = XW'(sr);
    xeq = XW'(eq);
    xer = XW'(er);
    xss = -xsq - xsr;
    xes = -xeq - xer;
    oor = (xsq > BOUND) || (xsq < -BOUND) || (xsr > BOUND) || (xsr < -BOUND) ||
          (xss > BOUND) || (xss < -BOUND) || (xeq > BOUND) || (xeq < -BOUND) ||
          (xer > BOUND) || (xer < -BOUND) || (xes > BOUND) || (xes < -BOUND);
    xdq  = xeq - xsq;
    xdr  = xer - xsr;
    xds  = xes - xss;
    adq  = xdq[XW-1] ? -xdq : xdq;
    adr  = xdr[XW-1] ? -xdr : xdr;
    ads  = xds[XW-1] ? -xds : xds;
    // cube distance is the largest of the three absolute deltas
    span = adq;
    if (adr > span) span = adr;
    if (ads > span) span = ads;
  end

  // Coordinate lanes
  hgl_lane #(.COORD_WIDTH(W)) u_lane_q (
    .clk(clk), .ctrl(lctl), .start(xsq), .delta(xdq), .den(den),
    .value(rq), .err(erq)
  );

  hgl_lane #(.COORD_WIDTH(W)) u_lane_r (
    .clk(clk), .ctrl(lctl), .start(xsr), .delta(xdr), .den(den),
    .value(rr), .err(err_r)
  );

  hgl_lane #(.COORD_WIDTH(W)) u_lane_s (
    .clk(clk), .ctrl(lctl), .start(xss), .delta(xds), .den(den),
    .value(rs), .err(ers)
  );

  // Recompute the coordinate with the largest rounding error
  always_comb begin
    fq = rq;
    fr = rr;
    fs = rs;
    if (erq > err_r && erq > ers) begin
      fq = -rr - rs;
    end else if (err_r > ers) begin
      fr = -rq - rs;
    end else begin
      fs = -rq - rr;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid) state_next = ST_CHECK;
      ST_CHECK: state_next = oor ? ST_FLAG : ST_RUN;
      ST_FLAG:  if (out_free) state_next = ST_IDLE;
      ST_RUN:   if (out_free && idx == n_len) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req.ready = 1'b0;
    lctl      = '0;
    load_run  = 1'b0;
    load_flag = 1'b0;
    case (state)
      ST_IDLE:  req.ready = !rst;
      ST_CHECK: lctl.load = !oor;
      ST_FLAG:  load_flag = out_free;
      ST_RUN: begin
        lctl.adv = out_free;
        load_run = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Line length, denominator and hex counter
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      n_len <= span[W-1:0];
      den   <= (span == '0) ? W'(1) : span[W-1:0];
      idx   <= '0;
    end else if (load_run) begin
      idx <= idx + W'(1);
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_run || load_flag) begin
      o_valid <= 1'b1;
    end else if (hex.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_run) begin
      o_q    <= fq[W-1:0];
      o_r    <= fr[W-1:0];
      o_s    <= fs[W-1:0];
      o_idx  <= idx;
      o_len  <= n_len + W'(1);
      o_last <= (idx == n_len);
      o_oor  <= 1'b0;
    end else if (load_flag) begin
      o_q    <= '0;
      o_r    <= '0;
      o_s    <= '0;
      o_idx  <= '0;
      o_len  <= '0;
      o_last <= 1'b1;
      o_oor  <= 1'b1;
    end
  end

  assign hex.valid        = o_valid;
  assign hex.hex_q        = o_q;
  assign hex.hex_r        = o_r;
  assign hex.hex_s        = o_s;
  assign hex.step_index   = o_idx;
  assign hex.path_length  = o_len;
  assign hex.last         = o_last;
  assign hex.out_of_range = o_oor;

`ifndef ASSERT_OFF
  // Every hex beat keeps q + r + s = 0
  a_cube_sum: assert property (@(posedge clk) disable iff (rst)
    hex.valid |-> (hex.hex_q + hex.hex_r + hex.hex_s) == W'(0))
    else $error("hex beat breaks q+r+s=0");

  // The final hex of a run sits at index N
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (hex.valid && hex.last && !hex.out_of_range) |->
      (hex.step_index + W'(1)) == hex.path_length)
    else $error("last beat at wrong step index");

  // An accepted request goes to the range check next
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == ST_CHECK)
    else $error("request beat not followed by check");

  // Lanes never step while a beat is stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !hex.ready) |-> !lctl.adv)
    else $error("lanes advanced under stall");
`endif

endmodule

`default_nettype wire

### rtl/hgl_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One coordinate lane: keeps start*N + d*i as floor quotient k and
// remainder rem over den, steps it by d each hex and rounds it.
module hgl_lane import hgl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  lane_ctrl_t                    ctrl,
  input  logic signed [COORD_WIDTH+1:0] start,
  input  logic signed [COORD_WIDTH+1:0] delta,
  input  logic        [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH+1:0] value,
  output logic        [COORD_WIDTH-1:0] err
);

  localparam int W  = COORD_WIDTH;
  localparam int XW = COORD_WIDTH + 2;

  logic signed [XW-1:0] k;
  logic signed [XW-1:0] k_next;
  logic        [W-1:0]  rem;
  logic        [W-1:0]  rem_next;
  logic signed [XW-1:0] d;
  logic signed [XW-1:0] den_x;
  logic signed [XW-1:0] sum;
  logic signed [XW-1:0] sum_fix;
  logic        [W:0]    twice;
  logic        [W:0]    den_w;
  logic                 up;

  assign den_x = $signed({2'b00, den});

  // Step: |d| <= den, so at most one wrap either way
  always_comb begin
    sum     = $signed({2'b00, rem}) + d;
    sum_fix = sum;
    k_next  = k;
    if (sum >= den_x) begin
      sum_fix = sum - den_x;
      k_next  = k + XW'(1);
    end else if (sum[XW-1]) begin
      sum_fix = sum + den_x;
      k_next  = k - XW'(1);
    end
    rem_next = sum_fix[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      k   <= start;
      rem <= '0;
      d   <= delta;
    end else if (ctrl.adv) begin
      k   <= k_next;
      rem <= rem_next;
    end
  end

  // Round half away from zero; a half rounds up when k is not negative
  always_comb begin
    twice = {rem, 1'b0};
    den_w = {1'b0, den};
    up    = (twice > den_w) || ((twice == den_w) && !k[XW-1]);
    value = k + $signed({{(XW-1){1'b0}}, up});
    err   = up ? (den - rem) : rem;
  end

endmodule

`default_nettype wire
